// ===== rtl/core/bds_pkg.sv =====
// Package for the ARGB box downsampler: shared widths, constants and types.
package bds_pkg;

  // Pixel layout
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CHAN = 4;

  // Configuration register widths
  localparam int unsigned LG_W      = 3;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Source height limit and row counter width
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned ROW_W        = 12;

  // Parameter defaults
  localparam int unsigned MAX_SRC_WIDTH_DEF   = 4096;
  localparam int unsigned MAX_FACTOR_LOG2_DEF = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR_LOG2 = 2'd0,
    CFG_SRC_WIDTH   = 2'd1,
    CFG_SRC_HEIGHT  = 2'd2
  } bds_cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_PUSH
  } bds_state_e;

endpackage

// ===== rtl/core/box_downsample_argb_unit.sv =====
// Top level of the ARGB box downsampler: position tracking, column-sum memory and sequencer.
//
// Source pixels enter in raster order and leave as per-channel block averages over a
// 2^factor_log2 square. A pixel outside every full block is taken without touching the
// sum memory. For a pixel inside a block, its column-sum entry is read from the single-port
// sum memory and written back updated. The pixel that completes a block then goes through
// the bit-serial divider and the load of the output register, which waits while the output
// register stays stalled. A finished word waits in the output register while the next
// pixels are taken. A write to a configuration register restarts the frame at row 0,
// column 0. The sum memory has no reset; each block's first pixel overwrites its entry.
module box_downsample_argb_unit #(
  parameter int unsigned MAX_SRC_WIDTH   = bds_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR_LOG2 = bds_pkg::MAX_FACTOR_LOG2_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bds_pkg::DIM_W-1:0]       cfg_wdata_i,
  // source pixel channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bds_pkg::PIXEL_W-1:0]     source_pixel_i,
  // averaged pixel channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bds_pkg::PIXEL_W-1:0]     average_pixel_o,
  output logic                            end_of_row_o,
  output logic                            end_of_frame_o
);
  import bds_pkg::*;

  localparam int unsigned ADDR_W  = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int unsigned WD_W    = ADDR_W + 1;
  localparam int unsigned F_W     = MAX_FACTOR_LOG2 + 1;
  localparam int unsigned SUM_W   = CHAN_W + 2 * MAX_FACTOR_LOG2;
  localparam int unsigned CNT_W   = 2 * MAX_FACTOR_LOG2 + 1;
  localparam int unsigned ENTRY_W = NUM_CHAN * SUM_W;

  // Configuration registers
  logic [LG_W-1:0]  factor_log2_q;
  logic [DIM_W-1:0] src_width_q;
  logic [DIM_W-1:0] src_height_q;

  // Frame position
  logic [ADDR_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  // Pending pixel
  logic [PIXEL_W-1:0] pix_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               first_q, last_q, eor_q, eof_q;
  logic [CNT_W-1:0]   cnt_q;

  bds_state_e state_q, state_d;

  // Output register
  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pix_q;
  logic               out_eor_q, out_eof_q;

  // Sum memory
  logic [ENTRY_W-1:0] sum_mem [MAX_SRC_WIDTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ENTRY_W-1:0] wdata;
  logic               mem_re, mem_we;

  // Control
  logic in_accept, out_free, out_load, div_start;
  logic div_busy, div_done;
  logic [PIXEL_W-1:0] div_quot;

  // Effective geometry from the registers
  logic [LG_W-1:0]  lg;
  logic [F_W-1:0]   f, f_mask, bw, bh;
  logic [WD_W-1:0]  w_eff, dw;
  logic [DIM_W-1:0] h_eff, dh;
  logic [ADDR_W-1:0] oc;
  logic [ROW_W-1:0]  orow;
  logic [F_W-1:0]    cin, rin;
  logic              in_block, is_first, is_last, is_eor, is_eof;
  logic [WD_W-1:0]   col_inc;
  logic [DIM_W-1:0]  row_inc;

  always_comb begin
    lg = (factor_log2_q > LG_W'(MAX_FACTOR_LOG2)) ? LG_W'(MAX_FACTOR_LOG2) : factor_log2_q;
    f      = F_W'(1) << lg;
    f_mask = f - 1'b1;

    if (src_width_q == '0) w_eff = WD_W'(1);
    else if (32'(src_width_q) > MAX_SRC_WIDTH) w_eff = WD_W'(MAX_SRC_WIDTH);
    else w_eff = WD_W'(src_width_q);

    if (src_height_q == '0) h_eff = DIM_W'(1);
    else if (32'(src_height_q) > HEIGHT_LIMIT) h_eff = DIM_W'(HEIGHT_LIMIT);
    else h_eff = src_height_q;

    dw = w_eff >> lg;
    if (dw == '0) dw = WD_W'(1);
    dh = h_eff >> lg;
    if (dh == '0) dh = DIM_W'(1);

    bw = (32'(f) < 32'(w_eff)) ? f : F_W'(w_eff);
    bh = (32'(f) < 32'(h_eff)) ? f : F_W'(h_eff);

    oc   = col_q >> lg;
    orow = row_q >> lg;
    cin  = F_W'(col_q) & f_mask;
    rin  = F_W'(row_q) & f_mask;

    in_block = ({1'b0, oc} < dw) && ({1'b0, orow} < dh);
    is_first = (cin == '0) && (rin == '0);
    is_last  = (cin == bw - 1'b1) && (rin == bh - 1'b1);
    is_eor   = ({1'b0, oc} == dw - 1'b1);
    is_eof   = is_eor && ({1'b0, orow} == dh - 1'b1);
  end

  // Raster position advance; a register write restarts the frame
  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_d   = col_q;
    row_d   = row_q;
    if (in_accept) begin
      if (col_inc == w_eff) begin
        col_d = '0;
        row_d = (row_inc == h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[ADDR_W-1:0];
      end
    end
    if (cfg_we_i && (cfg_index_i inside {CFG_FACTOR_LOG2, CFG_SRC_WIDTH, CFG_SRC_HEIGHT})) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // Configuration and position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_log2_q <= '0;
      src_width_q   <= DIM_W'(4096);
      src_height_q  <= DIM_W'(4096);
      col_q         <= '0;
      row_q         <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FACTOR_LOG2: begin
            factor_log2_q <= cfg_wdata_i[LG_W-1:0];
          end
          CFG_SRC_WIDTH: begin
            src_width_q <= cfg_wdata_i;
          end
          CFG_SRC_HEIGHT: begin
            src_height_q <= cfg_wdata_i;
          end
          default: ;
        endcase
      end
    end
  end

  // Pending pixel capture at accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q   <= source_pixel_i;
      addr_q  <= oc;
      first_q <= is_first;
      last_q  <= is_last;
      eor_q   <= is_eor;
      eof_q   <= is_eof;
      cnt_q   <= CNT_W'(bw * bh);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept && in_block) state_d = ST_RMW;
      ST_RMW:  state_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (div_done) state_d = out_free ? ST_IDLE : ST_PUSH;
      end
      ST_PUSH: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: mem_re = in_valid_i && in_block;
      ST_RMW: begin
        mem_we    = 1'b1;
        div_start = last_q;
      end
      ST_DIV:  out_load = div_done && out_free;
      ST_PUSH: out_load = out_free;
      default: ;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Sum update: restart on a block's first pixel, else accumulate
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      logic [SUM_W-1:0] chan;
      chan = SUM_W'(pix_q[(NUM_CHAN-1-k)*CHAN_W +: CHAN_W]);
      wdata[(NUM_CHAN-1-k)*SUM_W +: SUM_W] =
        first_q ? chan : (rdata_q[(NUM_CHAN-1-k)*SUM_W +: SUM_W] + chan);
    end
  end

  // Column-sum memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) sum_mem[addr_q] <= wdata;
    if (mem_re) rdata_q <= sum_mem[oc];
  end

  bds_div #(
    .MAX_FACTOR_LOG2(MAX_FACTOR_LOG2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sums_i  (wdata),
    .cnt_i   (cnt_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q <= div_quot;
      out_eor_q <= eor_q;
      out_eof_q <= eof_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_pixel_o = out_pix_q;
  assign end_of_row_o    = out_eor_q;
  assign end_of_frame_o  = out_eof_q;

  // Checks
  a_rmw_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |-> $past(in_accept)) else $error("write back without a pixel");
  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !div_done) |-> div_busy) else $error("waiting on an idle divider");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i)) else $error("result word overwritten");
  a_eof_has_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_eof_q) |-> out_eor_q) else $error("frame end off a row end");

endmodule

// ===== rtl/core/bds_div.sv =====
// Four-lane restoring divider: channel sums by the block pixel count, one quotient bit a cycle.
module bds_div #(
  parameter int unsigned MAX_FACTOR_LOG2 = bds_pkg::MAX_FACTOR_LOG2_DEF,
  localparam int unsigned SUM_W = bds_pkg::CHAN_W + 2 * MAX_FACTOR_LOG2,
  localparam int unsigned CNT_W = 2 * MAX_FACTOR_LOG2 + 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [bds_pkg::NUM_CHAN*SUM_W-1:0] sums_i,
  input  logic [CNT_W-1:0]                 cnt_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [bds_pkg::PIXEL_W-1:0]      quot_o
);
  import bds_pkg::*;

  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned STEP_W = $clog2(CHAN_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CHAN_W - 1);

  logic [REM_W-1:0]  rem_q [NUM_CHAN];
  logic [REM_W-1:0]  rem_d [NUM_CHAN];
  logic [CHAN_W-1:0] quo_q [NUM_CHAN];
  logic [CHAN_W-1:0] quo_d [NUM_CHAN];
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  // One restoring step per lane; the quotient shifts in where the low dividend bits shift out
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      logic [REM_W-1:0] trial;
      logic             ge;
      trial    = {rem_q[k][REM_W-2:0], quo_q[k][CHAN_W-1]};
      ge       = (trial >= {1'b0, cnt_i});
      rem_d[k] = ge ? (trial - {1'b0, cnt_i}) : trial;
      quo_d[k] = {quo_q[k][CHAN_W-2:0], ge};
    end
  end

  // Lane datapath: the high part of the sum is below the count, so eight steps suffice
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (start_i) begin
        rem_q[k] <= REM_W'({1'b0, sums_i[(NUM_CHAN-1-k)*SUM_W +: SUM_W]} >> CHAN_W);
        quo_q[k] <= sums_i[(NUM_CHAN-1-k)*SUM_W +: CHAN_W];
      end else if (busy_q) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  // Step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == LAST_STEP);
      if (start_i) begin
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      quot_o[(NUM_CHAN-1-k)*CHAN_W +: CHAN_W] = quo_q[k];
    end
  end

  // Checks
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q)) else $error("done without a running division");
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && step_q == LAST_STEP) |=> done_q)
    else $error("division did not finish on its last step");

endmodule

// ===== tb/box_downsample_argb_unit_tb.sv =====
// Self-checking testbench for the ARGB box downsampler: predicts block averages and checks every output word.
module box_downsample_argb_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bds_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned RANDOM_WORDS   = 360;
  localparam int unsigned WIDE_WORDS     = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // One averaged output word as the block should emit it
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
  } avg_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 src_valid = 1'b0;
  logic                 src_stall;
  logic [PIXEL_W-1:0]   src_pixel = '0;
  logic                 avg_valid;
  logic                 avg_stall = 1'b0;
  logic [PIXEL_W-1:0]   avg_pixel;
  logic                 avg_row_end;
  logic                 avg_frame_end;

  box_downsample_argb_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (src_valid),
    .in_stall_o     (src_stall),
    .source_pixel_i (src_pixel),
    .out_valid_o    (avg_valid),
    .out_stall_i    (avg_stall),
    .average_pixel_o(avg_pixel),
    .end_of_row_o   (avg_row_end),
    .end_of_frame_o (avg_frame_end)
  );

  wire src_fire = src_valid && !src_stall;
  wire avg_fire = avg_valid && !avg_stall;

  // Shadow copy of the block state
  logic [LG_W-1:0]   cur_factor_lg = '0;
  logic [DIM_W-1:0]  cur_width = DIM_W'(MAX_SRC_WIDTH_DEF);
  logic [DIM_W-1:0]  cur_height = DIM_W'(HEIGHT_LIMIT);
  logic [ROW_W-1:0]  next_col = '0;
  logic [ROW_W-1:0]  next_row = '0;
  logic [15:0]       col_sum [MAX_SRC_WIDTH_DEF][NUM_CHAN];

  logic [PIXEL_W-1:0] pixel_queue [$];
  avg_word_t          avg_expected [$];
  int unsigned        words_queued = 0;
  int unsigned        words_sent = 0;
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;

  // Sender and receiver idle controls, changed per phase
  bit                 send_gaps = 1'b0;
  int unsigned        stall_mode = 0;
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  logic [3:0]         stall_tick = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Zero means 1, anything above the limit saturates
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Accumulate one source pixel into its column sums; queue the block average when complete
  function automatic void accumulate_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned lg, f, w, h, dw, dh, bw, bh, c, r, oc, orow, cin, rin, cnt;
    avg_word_t   word;
    lg = (cur_factor_lg > MAX_FACTOR_LOG2_DEF) ? MAX_FACTOR_LOG2_DEF : cur_factor_lg;
    f  = 1 << lg;
    w  = eff_dim(cur_width, MAX_SRC_WIDTH_DEF);
    h  = eff_dim(cur_height, HEIGHT_LIMIT);
    dw = (w >> lg == 0) ? 1 : w >> lg;
    dh = (h >> lg == 0) ? 1 : h >> lg;
    bw = (f < w) ? f : w;
    bh = (f < h) ? f : h;
    c  = (next_col >= w) ? 0 : next_col;
    r  = (next_row >= h) ? 0 : next_row;
    oc   = c >> lg;
    orow = r >> lg;
    cin  = c & (f - 1);
    rin  = r & (f - 1);
    if (oc < dw && orow < dh) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        if (cin == 0 && rin == 0)
          col_sum[oc][k] = 16'(px[(NUM_CHAN-1-k)*CHAN_W +: CHAN_W]);
        else
          col_sum[oc][k] = col_sum[oc][k] + px[(NUM_CHAN-1-k)*CHAN_W +: CHAN_W];
      end
      if (cin == bw - 1 && rin == bh - 1) begin
        cnt = bw * bh;
        for (int k = 0; k < NUM_CHAN; k++)
          word.pixel[(NUM_CHAN-1-k)*CHAN_W +: CHAN_W] = CHAN_W'(col_sum[oc][k] / cnt);
        word.row_end   = (oc == dw - 1);
        word.frame_end = (oc == dw - 1) && (orow == dh - 1);
        avg_expected.push_back(word);
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = ROW_W'(c);
    next_row = ROW_W'(r);
  endfunction

  // Source driver: bursts of words, with random gaps between bursts when send_gaps is set
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      if (src_fire) begin
        accumulate_pixel(src_pixel);
        words_sent <= words_sent + 1;
      end
      if (!src_valid || src_fire) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          src_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          src_valid <= 1'b1;
          src_pixel <= pixel_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= (send_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Output receiver: stall pattern and field-by-field check
  always @(posedge clk_i) begin
    avg_word_t want;
    stall_tick <= stall_tick + 4'd1;
    case (stall_mode)
      0:       avg_stall <= 1'b0;
      1:       avg_stall <= ($urandom_range(0, 2) == 0);
      default: avg_stall <= (stall_tick < 4'd6);
    endcase
    if (rst_n && avg_fire) begin
      if (avg_expected.size() == 0) begin
        $error("unexpected word: average_pixel %h end_of_row %b end_of_frame %b",
               avg_pixel, avg_row_end, avg_frame_end);
        mismatches++;
      end else begin
        want = avg_expected.pop_front();
        if (avg_pixel !== want.pixel) begin
          $error("average_pixel: expected %h, got %h", want.pixel, avg_pixel);
          mismatches++;
        end
        if (avg_row_end !== want.row_end) begin
          $error("end_of_row: expected %b, got %b", want.row_end, avg_row_end);
          mismatches++;
        end
        if (avg_frame_end !== want.frame_end) begin
          $error("end_of_frame: expected %b, got %b", want.frame_end, avg_frame_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_pixel(input logic [PIXEL_W-1:0] px);
    pixel_queue.push_back(px);
    words_queued++;
  endtask

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Block idle: all words taken, all averages seen, in-flight pixels settled
  task automatic wait_idle();
    while (words_sent != words_queued || avg_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FACTOR_LOG2: cur_factor_lg = value[LG_W-1:0];
      CFG_SRC_WIDTH:   cur_width = value;
      CFG_SRC_HEIGHT:  cur_height = value;
      default: ;
    endcase
    if (idx != CFG_SPARE_IDX) begin
      next_col = '0;
      next_row = '0;
    end
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DIM_W'($urandom_range(MAX_SRC_WIDTH_DEF, 8191));
      default: return DIM_W'($urandom_range(1, 24));
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned random_sent;
    int unsigned frame_px;
    int unsigned count;
    bit          wrote;
    logic [LG_W-1:0] lg;

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset settings: factor 1, every pixel passes through unchanged
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'hAA55_AA55);
    queue_pixel(32'h55AA_55AA);
    queue_pixel(32'h8000_0001);
    queue_pixel(32'h7FFF_FFFE);
    wait_idle();

    // 2x2 blocks on a 4x2 frame, truncating averages
    send_gaps  = 1'b1;
    stall_mode = 1;
    write_reg(CFG_FACTOR_LOG2, 13'd1);
    write_reg(CFG_SRC_WIDTH, 13'd4);
    write_reg(CFG_SRC_HEIGHT, 13'd2);
    for (int i = 0; i < 8; i++) queue_pixel(i[0] ? 32'hFFFF_FFFF : 32'hFEFD_FC01);
    wait_idle();

    // Oversized factor with garbage upper bits, zero width, divide by 3, frame wrap
    stall_mode = 2;
    write_reg(CFG_FACTOR_LOG2, 13'h1FFF);
    write_reg(CFG_SRC_WIDTH, 13'd0);
    write_reg(CFG_SRC_HEIGHT, 13'd3);
    for (int i = 0; i < 6; i++) queue_pixel(rand_pixel());
    wait_idle();

    // Spare index changes nothing, frame position carries on
    write_reg(CFG_SPARE_IDX, DIM_W'($urandom()));
    for (int i = 0; i < 3; i++) queue_pixel(rand_pixel());
    wait_idle();

    // Oversized width saturates, zero height, factor 16
    send_gaps  = 1'b0;
    stall_mode = 1;
    write_reg(CFG_FACTOR_LOG2, 13'd4);
    write_reg(CFG_SRC_WIDTH, 13'h1FFF);
    write_reg(CFG_SRC_HEIGHT, 13'd0);
    for (int i = 0; i < WIDE_WORDS; i++) queue_pixel($urandom());
    wait_idle();

    // Random phases, mostly whole frames
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      send_gaps  = ($urandom_range(0, 3) != 0);
      stall_mode = $urandom_range(0, 2);
      wrote = 1'b0;
      while (!wrote) begin
        if ($urandom_range(0, 1)) begin
          lg = ($urandom_range(0, 9) < 8) ? LG_W'($urandom_range(0, 4))
                                          : LG_W'($urandom_range(5, 7));
          write_reg(CFG_FACTOR_LOG2, {(DIM_W-LG_W)'($urandom_range(0, 1023)), lg});
          wrote = 1'b1;
        end
        if ($urandom_range(0, 1)) begin
          write_reg(CFG_SRC_WIDTH, rand_dim());
          wrote = 1'b1;
        end
        if ($urandom_range(0, 1)) begin
          write_reg(CFG_SRC_HEIGHT, rand_dim());
          wrote = 1'b1;
        end
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_IDX, DIM_W'($urandom()));
      frame_px = eff_dim(cur_width, MAX_SRC_WIDTH_DEF) * eff_dim(cur_height, HEIGHT_LIMIT);
      if (frame_px > 600)
        count = $urandom_range(1, 64);
      else if ($urandom_range(0, 9) < 7)
        count = frame_px * ((frame_px * 2 <= 600) ? $urandom_range(1, 2) : 1);
      else
        count = $urandom_range(1, frame_px);
      if (count > RANDOM_WORDS - random_sent) count = RANDOM_WORDS - random_sent;
      for (int i = 0; i < count; i++) queue_pixel(rand_pixel());
      random_sent += count;
      wait_idle();
    end

    if (mismatches == 0 && avg_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
